// File: sv/sha1s_pkg.sv
// sha1s_pkg: types and constants shared by the byte-serial SHA-1 core.
// Holds the transaction payload structs, SHA-1 initial values, round constants
// and the round functions. No dependencies.
package sha1s_pkg;

    localparam int DIGEST_WORDS = 5;
    localparam int ROUNDS       = 80;
    localparam int ROUND_W      = $clog2(ROUNDS);
    localparam int INDEX_W      = 3;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] FILL_END = 6'd63;

    // Command codes
    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        digest_word;
        logic [INDEX_W-1:0] word_index;
        logic               last_word;
    } t_out_item;

    function automatic logic [31:0] sha1s_k(input logic [ROUND_W-1:0] round);
        logic [31:0] k;
        if (round < ROUND_W'(20))      k = K0;
        else if (round < ROUND_W'(40)) k = K1;
        else if (round < ROUND_W'(60)) k = K2;
        else                           k = K3;
        return k;
    endfunction

    function automatic logic [31:0] sha1s_f(input logic [ROUND_W-1:0] round,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        if (round < ROUND_W'(20))      f = (b & c) | (~b & d);
        else if (round < ROUND_W'(40)) f = b ^ c ^ d;
        else if (round < ROUND_W'(60)) f = (b & c) | (b & d) | (c & d);
        else                           f = b ^ c ^ d;
        return f;
    endfunction

endpackage

// File: sv/sha1_stream_hash_core.sv
// sha1_stream_hash_core: byte-serial SHA-1 hasher, top level.
// Contains the block buffer, message schedule window, round unit and sequencer.
// Depends on sha1s_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_item): each transaction is
//   either an absorb (one message byte) or a finish. Output channel
//   (o_out_valid / i_out_stall / o_out_item): a finish yields five
//   transactions carrying the digest words, index 0 first, last_word on the
//   fifth. Absorbs yield nothing.
//   Sequencing: the absorb that fills the 64-byte buffer is followed by a
//   compression: 80 rounds of the single shared round adder (one round per
//   cycle), then a fold of the result into the chaining words. A finish
//   feeds padding one byte per cycle (9 to 72 bytes), compressing once or
//   twice along the way, then presents the five digest words. The sustained
//   absorb rate is set by the round unit: no byte enters while it runs.
//   o_in_stall is high whenever the core is not idle. While the receiver
//   stalls, the current digest word holds and the core waits.
//   Reset (synchronous, active low) restores the SHA-1 initial values, clears
//   the byte count and length, and abandons any message in progress.
module sha1_stream_hash_core
    import sha1s_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_COMP = 5'b00100,
        S_ADD  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // chaining words, rotated during digest output
    logic [31:0] r_chain [DIGEST_WORDS];
    logic [31:0] n_chain [DIGEST_WORDS];

    // 64-byte buffer; bytes shift in at the bottom, during compression it is
    // the 16-word schedule window with W[t] in the top word
    logic [511:0] r_blk, n_blk;
    logic [5:0]   r_fill, n_fill;
    logic [63:0]  r_msg_len, n_msg_len;

    // working variables of the round unit
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_a, n_b, n_c, n_d, n_e;
    logic [ROUND_W-1:0] r_round, n_round;

    // padding control
    logic r_fin, n_fin;       // finishing a message
    logic r_mark, n_mark;     // 0x80 marker still to place
    logic r_in_len, n_in_len; // length field being written

    logic [INDEX_W-1:0] r_oidx, n_oidx;

    logic        in_acc, out_acc;
    logic [7:0]  pad_byte;
    logic        pad_is_len;
    logic [31:0] w0, w2, w8, w13, w_x, w_new;
    logic [31:0] rnd_sum;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    assign o_out_item.digest_word = r_chain[0];
    assign o_out_item.word_index  = r_oidx;
    assign o_out_item.last_word   = (r_oidx == INDEX_W'(DIGEST_WORDS - 1));

    // schedule taps: W[t], W[t+2], W[t+8], W[t+13]
    assign w0    = r_blk[511:480];
    assign w2    = r_blk[447:416];
    assign w8    = r_blk[255:224];
    assign w13   = r_blk[95:64];
    assign w_x   = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_x[30:0], w_x[31]};

    // the one round adder
    assign rnd_sum = {r_a[26:0], r_a[31:27]} + sha1s_f(r_round, r_b, r_c, r_d)
                   + r_e + sha1s_k(r_round) + w0;

    // padding byte: marker, then zeros, then length big-endian from position 56
    assign pad_is_len = !r_mark && (r_in_len || (r_fill == LEN_POS));
    always_comb begin
        if (r_mark)          pad_byte = PAD_MARK;
        else if (pad_is_len) pad_byte = r_msg_len[63:56];
        else                 pad_byte = 8'h00;
    end

    always_comb begin
        n_state   = r_state;
        n_chain   = r_chain;
        n_blk     = r_blk;
        n_fill    = r_fill;
        n_msg_len = r_msg_len;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        n_e       = r_e;
        n_round   = r_round;
        n_fin     = r_fin;
        n_mark    = r_mark;
        n_in_len  = r_in_len;
        n_oidx    = r_oidx;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.command == CMD_FINISH) begin
                        n_fin    = 1'b1;
                        n_mark   = 1'b1;
                        n_in_len = 1'b0;
                        n_state  = S_PAD;
                    end else begin
                        n_blk     = {r_blk[503:0], i_in_item.data_byte};
                        n_fill    = r_fill + 6'd1;
                        n_msg_len = r_msg_len + 64'd8;
                        n_fin     = 1'b0;
                        if (r_fill == FILL_END) begin
                            n_state = S_COMP;
                            n_round = '0;
                            n_a = r_chain[0];
                            n_b = r_chain[1];
                            n_c = r_chain[2];
                            n_d = r_chain[3];
                            n_e = r_chain[4];
                        end
                    end
                end
            end
            S_PAD: begin
                n_blk  = {r_blk[503:0], pad_byte};
                n_fill = r_fill + 6'd1;
                n_mark = 1'b0;
                if (pad_is_len) begin
                    n_in_len  = 1'b1;
                    n_msg_len = {r_msg_len[55:0], 8'h00};
                end
                if (r_fill == FILL_END) begin
                    n_state = S_COMP;
                    n_round = '0;
                    n_a = r_chain[0];
                    n_b = r_chain[1];
                    n_c = r_chain[2];
                    n_d = r_chain[3];
                    n_e = r_chain[4];
                end
            end
            S_COMP: begin
                n_a     = rnd_sum;
                n_b     = r_a;
                n_c     = {r_b[1:0], r_b[31:2]};
                n_d     = r_c;
                n_e     = r_d;
                n_blk   = {r_blk[479:0], w_new};
                n_round = r_round + ROUND_W'(1);
                if (r_round == ROUND_W'(ROUNDS - 1)) n_state = S_ADD;
            end
            S_ADD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                n_chain[4] = r_chain[4] + r_e;
                if (!r_fin)        n_state = S_IDLE;
                else if (r_in_len) begin
                    n_state = S_OUT;
                    n_oidx  = '0;
                end else           n_state = S_PAD;
            end
            S_OUT: begin
                if (out_acc) begin
                    n_oidx = r_oidx + INDEX_W'(1);
                    for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                        n_chain[i] = r_chain[i + 1];
                    end
                    n_chain[DIGEST_WORDS - 1] = r_chain[0];
                    if (o_out_item.last_word) begin
                        n_chain[0] = H0;
                        n_chain[1] = H1;
                        n_chain[2] = H2;
                        n_chain[3] = H3;
                        n_chain[4] = H4;
                        n_fill     = '0;
                        n_msg_len  = '0;
                        n_fin      = 1'b0;
                        n_in_len   = 1'b0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and context state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_chain[0] <= H0;
            r_chain[1] <= H1;
            r_chain[2] <= H2;
            r_chain[3] <= H3;
            r_chain[4] <= H4;
            r_fill     <= '0;
            r_msg_len  <= '0;
            r_round    <= '0;
            r_fin      <= 1'b0;
            r_mark     <= 1'b0;
            r_in_len   <= 1'b0;
            r_oidx     <= '0;
        end else begin
            r_state   <= n_state;
            r_chain   <= n_chain;
            r_fill    <= n_fill;
            r_msg_len <= n_msg_len;
            r_round   <= n_round;
            r_fin     <= n_fin;
            r_mark    <= n_mark;
            r_in_len  <= n_in_len;
            r_oidx    <= n_oidx;
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
    end

    // checks
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.last_word == (o_out_item.word_index == 3'd4)))
        else $error("last_word out of step with word_index");

    a_ctx_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_item.last_word) |=>
            (r_fill == 6'd0 && r_msg_len == 64'd0 && r_chain[0] == H0))
        else $error("context not restored after digest");

    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP && r_round == ROUND_W'(ROUNDS - 1)) |=> (r_state == S_ADD))
        else $error("compression did not end after last round");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> (r_round < ROUND_W'(ROUNDS)))
        else $error("round counter out of range");

endmodule

// File: sim/tb.sv
// tb: self-checking testbench for sha1_stream_hash_core, the byte-serial SHA-1 hasher.
// Drives absorb and finish transactions and checks each digest word against a SHA-1
// model kept inside the bench. Depends on sha1s_pkg and sha1_stream_hash_core.
module tb
    import sha1s_pkg::*;
();

    // Upper bound on the run, far above its length even if every transaction were
    // a finish with the longest sender gap, two compressions and every digest word
    // held by the longest receiver stall.
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 1500;   // long receiver hold-off
    localparam int RANDOM_ITEMS = 207;
    localparam int TAIL_CYCLES  = 200;    // drain time once no words are owed

    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;

    // One row of the directed table. Where typed is set the digest is written out
    // by hand; otherwise the SHA-1 model below supplies it.
    typedef struct {
        logic         command;
        logic [7:0]   data_byte;
        bit           typed;
        logic [159:0] digest;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    sha1_stream_hash_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // SHA-1 model: chaining words, block buffer, fill count, bit length
    // ------------------------------------------------------------------
    logic [31:0] chain_words [5];
    logic [7:0]  block_bytes [64];
    int unsigned block_fill;
    logic [63:0] msg_bits;

    t_out_item   owed_words [$];   // digest words still to arrive, oldest first
    t_dir_row    dir_rows [$];     // directed stimulus table
    int          mismatches = 0;
    int          words_seen = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;      // both sides run without gaps while set

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void sha1_context_init();
        chain_words[0] = 32'h67452301;
        chain_words[1] = 32'hEFCDAB89;
        chain_words[2] = 32'h98BADCFE;
        chain_words[3] = 32'h10325476;
        chain_words[4] = 32'hC3D2E1F0;
        block_fill     = 0;
        msg_bits       = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, nxt;
        for (int t = 0; t < 16; t++)
            w[t] = {block_bytes[4*t], block_bytes[4*t+1],
                    block_bytes[4*t+2], block_bytes[4*t+3]};
        for (int t = 16; t < 80; t++)
            w[t] = rotl32(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            nxt = rotl32(a, 5) + f + e + k + w[t];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = nxt;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
        chain_words[4] += e;
    endfunction

    function automatic void sha1_put_byte(input logic [7:0] v);
        block_bytes[block_fill] = v;
        block_fill++;
        if (block_fill == 64) begin
            sha1_compress();
            block_fill = 0;
        end
    endfunction

    // Applies one transaction; returns 1 with the digest when it was a finish.
    function automatic bit sha1_step(input t_in_item it, output logic [31:0] digest [5]);
        logic [63:0] len;
        if (it.command == CMD_ABSORB) begin
            msg_bits += 64'd8;   // wraps mod 2^64 by width
            sha1_put_byte(it.data_byte);
            return 1'b0;
        end
        len = msg_bits;
        sha1_put_byte(8'h80);
        while (block_fill != 56)
            sha1_put_byte(8'h00);
        for (int i = 0; i < 8; i++)
            sha1_put_byte(len[63-8*i -: 8]);
        for (int i = 0; i < 5; i++)
            digest[i] = chain_words[i];
        sha1_context_init();
        return 1'b1;
    endfunction

    // Gap before a transaction or length of a receiver stall: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer one transaction at a falling edge, hold it until it
    // is taken at a rising edge, then update the model.
    // ------------------------------------------------------------------
    task automatic send_item(input t_in_item it, input bit typed, input logic [159:0] digest);
        int          gap;
        logic [31:0] words [5];
        t_out_item   owed;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (sha1_step(it, words)) begin
            for (int i = 0; i < 5; i++) begin
                owed.digest_word = typed ? digest[159-32*i -: 32] : words[i];
                owed.word_index  = INDEX_W'(i);
                owed.last_word   = (i == 4);
                owed_words.insert(owed_words.size(), owed);
            end
        end
    endtask

    task automatic send_random(input logic cmd);
        t_in_item it;
        it.command   = cmd;
        it.data_byte = 8'($urandom_range(0, 255));
        send_item(it, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall runs, one long hold-off once a couple of
    // digests have come through so that the core backs up onto its input.
    // ------------------------------------------------------------------
    initial begin
        int   run;
        bit   level;
        bit   hold_done;
        run       = 0;
        level     = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && words_seen >= 10) begin
                hold_done = 1'b1;
                level     = 1'b1;
                run       = HOLD_CYCLES;
            end else if (run == 0) begin
                level = !calm && ($urandom_range(0, 3) == 0);
                run   = level ? pick_gap() : $urandom_range(1, 10);
                if (run == 0)
                    run = 1;
            end
            i_out_stall <= level;
            run--;
        end
    end

    // Compare each digest word taken against the oldest owed one
    always @(posedge i_clk) begin
        t_out_item exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_seen++;
            if (owed_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected digest word %h idx %0d last %b", $time,
                         o_out_item.digest_word, o_out_item.word_index, o_out_item.last_word);
            end else begin
                exp_w = owed_words.pop_front();
                if (o_out_item.digest_word !== exp_w.digest_word ||
                    o_out_item.word_index !== exp_w.word_index ||
                    o_out_item.last_word !== exp_w.last_word) begin
                    mismatches++;
                    $display("%0t: expected %h idx %0d last %b, got %h idx %0d last %b", $time,
                             exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                             o_out_item.digest_word, o_out_item.word_index,
                             o_out_item.last_word);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Appends one row to the directed table
    function automatic void add_row(input logic cmd, input logic [7:0] data,
                                    input bit typed, input logic [159:0] digest);
        t_dir_row r;
        r.command   = cmd;
        r.data_byte = data;
        r.typed     = typed;
        r.digest    = digest;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_in_item    it;
        int          sent;
        int          msg_len;
        int          r;
        int          boundary [10];

        boundary = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
        sha1_context_init();

        // Directed table: empty message straight after reset, a finish whose
        // data byte must be ignored, back-to-back finishes, byte extremes,
        // a byte equal to the padding marker, and walking-one bytes.
        add_row(CMD_FINISH, 8'h00, 1'b1, EMPTY_DIGEST);
        add_row(CMD_FINISH, 8'hFF, 1'b1, EMPTY_DIGEST);
        add_row(CMD_ABSORB, 8'h00, 1'b0, '0);
        add_row(CMD_ABSORB, 8'hFF, 1'b0, '0);
        add_row(CMD_FINISH, 8'h00, 1'b0, '0);
        add_row(CMD_ABSORB, 8'h61, 1'b0, '0);
        add_row(CMD_ABSORB, 8'h62, 1'b0, '0);
        add_row(CMD_ABSORB, 8'h63, 1'b0, '0);
        add_row(CMD_FINISH, 8'h5A, 1'b0, '0);
        add_row(CMD_ABSORB, 8'h80, 1'b0, '0);
        add_row(CMD_ABSORB, 8'h55, 1'b0, '0);
        add_row(CMD_ABSORB, 8'hAA, 1'b0, '0);
        add_row(CMD_FINISH, 8'hA5, 1'b0, '0);
        add_row(CMD_FINISH, 8'h00, 1'b1, EMPTY_DIGEST);
        for (int b = 0; b < 8; b++)
            add_row(CMD_ABSORB, 8'(1 << b), 1'b0, '0);
        add_row(CMD_FINISH, 8'hFF, 1'b0, '0);

        // Reset once, released at a falling edge
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            it.command   = dir_rows[n].command;
            it.data_byte = dir_rows[n].data_byte;
            send_item(it, dir_rows[n].typed, dir_rows[n].digest);
        end

        // Random messages. Lengths favour short ones, with the padding
        // boundaries (55/56 bytes, one block vs two; also 63/64 and 119/120) picked often.
        // The last message is cut short so the total stays on budget.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 20)
                msg_len = boundary[$urandom_range(0, 9)];
            else if (r < 88)
                msg_len = $urandom_range(0, 40);
            else
                msg_len = $urandom_range(41, 130);
            if (msg_len > RANDOM_ITEMS - sent - 1)
                msg_len = RANDOM_ITEMS - sent - 1;
            calm = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < msg_len; i++)
                send_random(CMD_ABSORB);
            send_random(CMD_FINISH);
            sent += msg_len + 1;
        end
        calm = 1'b0;

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        wait (owed_words.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
sv/sha1s_pkg.sv
sv/sha1_stream_hash_core.sv
sim/tb.sv
